FILE: rtl/yjkdec_pkg.sv
// Shared types, constants and helper functions for the YJK to RGB decoder.
package yjkdec_pkg;

    localparam int NUM_LANES = 4;
    localparam int Y_W       = 5;
    localparam int CHROMA_W  = 6;
    localparam int CHAN_W    = 8;
    localparam int SUM_W     = 9;
    localparam int LUMA_MAX  = 31;

    typedef struct packed {
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
    } t_yjk_in;

    typedef struct packed {
        logic [7:0] pix0_red;
        logic [7:0] pix0_green;
        logic [7:0] pix0_blue;
        logic [7:0] pix1_red;
        logic [7:0] pix1_green;
        logic [7:0] pix1_blue;
        logic [7:0] pix2_red;
        logic [7:0] pix2_green;
        logic [7:0] pix2_blue;
        logic [7:0] pix3_red;
        logic [7:0] pix3_green;
        logic [7:0] pix3_blue;
    } t_rgb_out;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pix;

    // floor(v * 255 / 31) for v in 0..31
    localparam logic [CHAN_W-1:0] EXPAND_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // Saturate a signed channel sum to 0..31.
    function automatic logic [Y_W-1:0] clamp5(input logic signed [SUM_W-1:0] v);
        logic [Y_W-1:0] res;
        if (v[SUM_W-1]) begin
            res = '0;
        end else if (v > SUM_W'(LUMA_MAX)) begin
            res = Y_W'(LUMA_MAX);
        end else begin
            res = v[Y_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/yjkdec_lane.sv
// One pixel lane: luma plus shared chroma to clamped, expanded RGB.
module yjkdec_lane (
    input  logic [yjkdec_pkg::Y_W-1:0]      i_luma,
    input  logic [yjkdec_pkg::CHROMA_W-1:0] i_chroma_j,
    input  logic [yjkdec_pkg::CHROMA_W-1:0] i_chroma_k,
    output yjkdec_pkg::t_pix                o_pix
);
    import yjkdec_pkg::*;

    logic signed [SUM_W-1:0] y_s;
    logic signed [SUM_W-1:0] j_s;
    logic signed [SUM_W-1:0] k_s;
    logic signed [SUM_W-1:0] j_adj;
    logic signed [SUM_W-1:0] k_adj;
    logic signed [SUM_W-1:0] j_half;
    logic signed [SUM_W-1:0] k_quarter;
    logic [7:0]              y_times5;
    logic signed [SUM_W-1:0] red_sum;
    logic signed [SUM_W-1:0] green_sum;
    logic signed [SUM_W-1:0] blue_sum;

    always_comb begin
        y_s      = $signed({{(SUM_W-Y_W){1'b0}}, i_luma});
        j_s      = $signed({{(SUM_W-CHROMA_W){i_chroma_j[CHROMA_W-1]}}, i_chroma_j});
        k_s      = $signed({{(SUM_W-CHROMA_W){i_chroma_k[CHROMA_W-1]}}, i_chroma_k});
        y_times5 = {1'b0, i_luma, 2'b00} + {3'b000, i_luma};
        // bias negatives so the arithmetic shift truncates toward zero
        j_adj     = j_s + $signed({{(SUM_W-1){1'b0}}, i_chroma_j[CHROMA_W-1]});
        k_adj     = k_s + $signed({{(SUM_W-2){1'b0}}, {2{i_chroma_k[CHROMA_W-1]}}});
        j_half    = j_adj >>> 1;
        k_quarter = k_adj >>> 2;
        red_sum   = y_s + j_s;
        green_sum = y_s + k_s;
        blue_sum  = $signed({3'b000, y_times5[7:2]}) - j_half - k_quarter;
        o_pix.red   = EXPAND_LUT[clamp5(red_sum)];
        o_pix.green = EXPAND_LUT[clamp5(green_sum)];
        o_pix.blue  = EXPAND_LUT[clamp5(blue_sum)];
    end

endmodule

FILE: rtl/yjkdec_merge.sv
// Merge stage: packs lane results into one group, output register plus skid entry.
module yjkdec_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  yjkdec_pkg::t_pix     i_lanes [yjkdec_pkg::NUM_LANES],
    output logic                 o_valid,
    input  logic                 i_ready,
    output yjkdec_pkg::t_rgb_out o_data
);
    import yjkdec_pkg::*;

    t_rgb_out packed_in;
    logic     in_xfer;

    logic     r_out_valid, n_out_valid;
    t_rgb_out r_out_data,  n_out_data;
    logic     r_skid_valid, n_skid_valid;
    t_rgb_out r_skid_data,  n_skid_data;

    always_comb begin
        packed_in.pix0_red   = i_lanes[0].red;
        packed_in.pix0_green = i_lanes[0].green;
        packed_in.pix0_blue  = i_lanes[0].blue;
        packed_in.pix1_red   = i_lanes[1].red;
        packed_in.pix1_green = i_lanes[1].green;
        packed_in.pix1_blue  = i_lanes[1].blue;
        packed_in.pix2_red   = i_lanes[2].red;
        packed_in.pix2_green = i_lanes[2].green;
        packed_in.pix2_blue  = i_lanes[2].blue;
        packed_in.pix3_red   = i_lanes[3].red;
        packed_in.pix3_green = i_lanes[3].green;
        packed_in.pix3_blue  = i_lanes[3].blue;
    end

    assign o_ready = !r_skid_valid;
    assign in_xfer = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                // drain the skid entry first; input is held off meanwhile
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = in_xfer;
                n_out_data  = packed_in;
            end
        end else if (in_xfer) begin
            // output stalled: park the new transfer
            n_skid_valid = 1'b1;
            n_skid_data  = packed_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_stall_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_out_valid && !i_ready) |=> r_skid_valid)
        else $error("transfer during output stall not parked");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry did not move to output");

    a_skid_data_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out_data == $past(r_skid_data)))
        else $error("output did not take skid data");

endmodule

FILE: rtl/yjk_to_rgb_decode_unit.sv
// Top level of the YJK to RGB decoder: chroma extraction, four pixel lanes, merge stage.
//
// Decodes one group of four YJK bytes into four 8-bit RGB pixels. A new group is taken
// every clock cycle while o_ready is high; results are registered (skid entry on a stall).
// All four pixel lanes run side by side, so throughput is set only by the output
// register: a two-entry output buffer (register plus skid entry) keeps o_ready
// registered and still takes a group while the previous result waits downstream.
// o_ready falls only after the downstream side has stalled with both entries full.
module yjk_to_rgb_decode_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  yjkdec_pkg::t_yjk_in  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output yjkdec_pkg::t_rgb_out o_data
);
    import yjkdec_pkg::*;

    logic [CHROMA_W-1:0] chroma_j;
    logic [CHROMA_W-1:0] chroma_k;
    logic [Y_W-1:0]      luma [NUM_LANES];
    t_pix                lane_pix [NUM_LANES];

    assign chroma_k = {i_data.byte_one[2:0],   i_data.byte_zero[2:0]};
    assign chroma_j = {i_data.byte_three[2:0], i_data.byte_two[2:0]};

    assign luma[0] = i_data.byte_zero[7:3];
    assign luma[1] = i_data.byte_one[7:3];
    assign luma[2] = i_data.byte_two[7:3];
    assign luma[3] = i_data.byte_three[7:3];

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        yjkdec_lane u_lane (
            .i_luma     (luma[g]),
            .i_chroma_j (chroma_j),
            .i_chroma_k (chroma_k),
            .o_pix      (lane_pix[g])
        );
    end

    yjkdec_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_lanes (lane_pix),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
